@@ hdl/tbhp_pkg.sv @@
// Shared types, status codes and header byte tables for the tagged blob header parser.
package tbhp_pkg;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_of_buffer;
    logic [31:0] bytes_available;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] payload_offset;
    logic [31:0] payload_length;
    logic [31:0] consumed_total;
  } out_item_t;

  localparam logic [1:0] ST_RAW   = 2'd0;
  localparam logic [1:0] ST_BLOB  = 2'd1;
  localparam logic [1:0] ST_OTHER = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  localparam logic [31:0] RAW_TAG_LEN  = 32'd4;
  localparam logic [31:0] BLOB_TAG_END = 32'd5;
  localparam logic [31:0] SKIP_POS     = 32'd21;
  localparam logic [31:0] FRAME_LAST   = 32'd26;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  function automatic logic [7:0] raw_byte(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = "r";
      2'd1:    c = "a";
      2'd2:    c = "w";
      default: c = ":";
    endcase
    return c;
  endfunction

  // Blob framing; the byte at SKIP_POS is not compared.
  function automatic logic [7:0] frame_byte(input logic [4:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0:    c = "b";
      5'd1:    c = "l";
      5'd2:    c = "o";
      5'd3:    c = "b";
      5'd4:    c = ":";
      5'd5:    c = 8'h00;
      5'd6:    c = "c";
      5'd7:    c = "o";
      5'd8:    c = "m";
      5'd9:    c = "p";
      5'd10:   c = "o";
      5'd11:   c = "n";
      5'd12:   c = "e";
      5'd13:   c = "n";
      5'd14:   c = "t";
      5'd15:   c = "=";
      // codec name
      5'd16:   c = 8'h7A;
      5'd17:   c = 8'h6C;
      5'd18:   c = 8'h69;
      5'd19:   c = 8'h62;
      5'd20:   c = ":";
      5'd21:   c = 8'h00;
      5'd22:   c = "s";
      5'd23:   c = "i";
      5'd24:   c = "z";
      5'd25:   c = "e";
      5'd26:   c = "=";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ hdl/tagged_blob_header_parser_unit.sv @@
// Tagged blob header parser: classifies a buffer header from a byte stream.
//
// Usage: feed the buffer one byte per request on the in_ channel; set
// first_of_buffer on the first byte, together with the number of readable
// bytes. At most one result leaves on the out_ channel per buffer, on the
// byte that decides it: raw accepted, blob accepted, not ours, or
// malformed. Bytes after a decision are dropped until the next first byte;
// a first byte in mid-buffer drops the open buffer and restarts.
// Throughput: one byte per cycle while no stalled result blocks it, set by the
// single decode and length-accumulate stage between the input and result registers.
// Result path: the deciding byte is taken into the input register, and the
// result register loads its verdict once it is free (not held by out_stall).
// Reset: synchronous, active low; clears both channel valids and returns
// the parser to waiting for a first byte.
// Stall: while out_stall holds a waiting result, the input register keeps
// its byte and in_stall rises once that register is also occupied.
module tagged_blob_header_parser_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tbhp_pkg::in_item_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output tbhp_pkg::out_item_t out_item
);
  import tbhp_pkg::*;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_TAG    = 3'd1;
  localparam logic [2:0] PH_RAW    = 3'd2;
  localparam logic [2:0] PH_FRAME  = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;
  localparam logic [2:0] PH_TERM   = 3'd5;

  logic       in_valid_r;
  in_item_t   in_item_r;
  logic       out_valid_r;
  out_item_t  out_item_r;

  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] left_r, left_nxt;
  logic [31:0] len_r, len_nxt;
  logic [1:0]  flags_r, flags_nxt;
  logic        dseen_r, dseen_nxt;

  logic      adv;
  logic      done;
  out_item_t res;

  logic [2:0]  cur_phase, ph;
  logic [31:0] cur_pos, cur_left, cur_len, dl;
  logic [1:0]  cur_flags, fl;
  logic        cur_dseen, ds;
  logic [7:0]  b;
  logic        raw_hit, blob_hit;
  logic [35:0] prod;
  logic [31:0] idx;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = in_valid_r && !adv;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    cur_phase = phase_r;
    cur_pos   = pos_r;
    cur_left  = left_r;
    cur_len   = len_r;
    cur_flags = flags_r;
    cur_dseen = dseen_r;
    b         = in_item_r.data_byte;
    done      = 1'b0;
    res       = '0;
    raw_hit   = 1'b0;
    blob_hit  = 1'b0;
    prod      = '0;
    idx       = 32'(pos_r + 32'd1);

    if (in_item_r.first_of_buffer) begin
      cur_phase = PH_TAG;
      cur_pos   = '0;
      cur_left  = 32'(in_item_r.bytes_available - 32'd1);
      cur_len   = '0;
      cur_flags = 2'b11;
      cur_dseen = 1'b0;
    end
    idx = 32'(cur_pos + 32'd1);
    ph  = cur_phase;
    fl  = cur_flags;
    dl  = cur_len;
    ds  = cur_dseen;

    if (in_item_r.first_of_buffer && in_item_r.bytes_available == '0) begin
      done       = 1'b1;
      res.status = ST_BAD;
    end else if (cur_phase != PH_IDLE) begin
      unique case (cur_phase)
        PH_TAG: begin
          raw_hit  = (cur_pos < RAW_TAG_LEN) && (b == raw_byte(cur_pos[1:0]));
          blob_hit = (cur_pos <= BLOB_TAG_END) && (b == frame_byte(cur_pos[4:0]));
          fl = cur_flags & {blob_hit, raw_hit};
          if (fl[0] && cur_pos == RAW_TAG_LEN - 32'd1) begin
            ph = PH_RAW;
          end else if (fl[1] && cur_pos == BLOB_TAG_END) begin
            ph = PH_FRAME;
          end else if (fl == 2'b00) begin
            done       = 1'b1;
            res.status = ST_OTHER;
          end
        end
        PH_RAW: begin
          if (b == CH_NUL) begin
            done               = 1'b1;
            res.status         = ST_RAW;
            res.payload_offset = RAW_TAG_LEN;
            res.payload_length = 32'(cur_pos - (RAW_TAG_LEN - 32'd1));
            res.consumed_total = idx;
          end
        end
        PH_FRAME: begin
          if (cur_pos > FRAME_LAST ||
              (cur_pos != SKIP_POS && b != frame_byte(cur_pos[4:0]))) begin
            done       = 1'b1;
            res.status = ST_BAD;
          end else if (cur_pos == FRAME_LAST) begin
            ph = PH_DIGITS;
            dl = '0;
            ds = 1'b0;
          end
        end
        PH_DIGITS: begin
          if (b >= CH_ZERO && b <= CH_NINE) begin
            // x*10 as x*8 + x*2, then saturate
            prod = {1'b0, cur_len, 3'b000} + {3'b000, cur_len, 1'b0} + {32'd0, b[3:0]};
            dl   = (prod[35:32] != 4'd0) ? '1 : prod[31:0];
            ds   = 1'b1;
          end else if (b == CH_COLON && cur_dseen) begin
            ph = PH_TERM;
          end else begin
            done       = 1'b1;
            res.status = ST_BAD;
          end
        end
        PH_TERM: begin
          done = 1'b1;
          // cur_left is the byte count behind this one; a saturated length never fits
          if (b != CH_NUL || cur_len > cur_left) begin
            res.status = ST_BAD;
          end else begin
            res.status         = ST_BLOB;
            res.payload_offset = idx;
            res.payload_length = cur_len;
            res.consumed_total = 32'(idx + cur_len);
          end
        end
        default: begin
          ph = PH_IDLE;
        end
      endcase

      // out of bytes
      if (!done && ph != PH_IDLE && cur_left == '0) begin
        done       = 1'b1;
        res.status = (ph == PH_TAG || ph == PH_RAW) ? ST_OTHER : ST_BAD;
      end
    end

    phase_nxt = done ? PH_IDLE : ph;
    pos_nxt   = idx;
    left_nxt  = 32'(cur_left - 32'd1);
    len_nxt   = dl;
    flags_nxt = fl;
    dseen_nxt = ds;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_IDLE;
      pos_r       <= '0;
      left_r      <= '0;
      len_r       <= '0;
      flags_r     <= 2'b11;
      dseen_r     <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= in_valid_r && done;
      end
      if (in_valid_r && adv) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        left_r  <= left_nxt;
        len_r   <= len_nxt;
        flags_r <= flags_nxt;
        dseen_r <= dseen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_item_r <= in_item;
    end
    if (adv && in_valid_r && done) begin
      out_item_r <= res;
    end
  end

endmodule

@@ hdl/tbhp_checker.sv @@
// Port-level checks for the tagged blob header parser, bound to the top level.
module tbhp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input tbhp_pkg::out_item_t out_item
);
  import tbhp_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result dropped or changed");

  // no stall back to the sender while the result side is free
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with an empty result register");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ST_OTHER || out_item.status == ST_BAD) |->
      out_item.payload_offset == '0 && out_item.payload_length == '0 &&
      out_item.consumed_total == '0)
    else $error("rejected header carries nonzero fields");

  a_raw_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_RAW |->
      out_item.payload_offset == RAW_TAG_LEN &&
      out_item.consumed_total == 32'(out_item.payload_offset + out_item.payload_length))
    else $error("raw result offset or total inconsistent");

  a_blob_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_BLOB |->
      out_item.payload_offset > FRAME_LAST &&
      out_item.consumed_total == 32'(out_item.payload_offset + out_item.payload_length))
    else $error("blob result offset or total inconsistent");

endmodule

bind tagged_blob_header_parser_unit tbhp_checker u_tbhp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

@@ tb/sv/tagged_blob_header_parser_unit_tb.sv @@
// Self-checking testbench for the tagged blob header parser unit.
`timescale 1ns / 1ps

module tagged_blob_header_parser_unit_tb;
  import tbhp_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1950;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  localparam logic [31:0]     RAW_TAG    = "raw:";
  localparam logic [8*27-1:0] BLOB_FRAME = {"blob:", CH_NUL, "component=",
                                            8'h7A, 8'h6C, 8'h69, 8'h62, // codec name
                                            CH_COLON, CH_NUL, "size="};

  typedef enum logic [2:0] {
    WAIT_FIRST, IN_TAG, IN_RAW_TEXT, IN_FRAME, IN_DIGITS, AT_TERM
  } parse_phase_e;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;

  // predicted parser state
  parse_phase_e phase_q = WAIT_FIRST;
  logic [31:0]  pos_q = '0;
  logic [31:0]  avail_q = '0;
  logic [31:0]  length_q = '0;
  logic [1:0]   cand_q = 2'b11;
  logic         digit_q = 1'b0;

  out_item_t    verdict_q[$];
  logic [7:0]   stream_q[$];
  int unsigned  live_count = 0;
  int unsigned  burst_left = 0;
  int unsigned  fail_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  stall_mode = 0;
  int unsigned  stall_run = 0;

  tagged_blob_header_parser_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [7:0] raw_at(input int unsigned i);
    if (i >= RAW_TAG_LEN) return CH_NUL;
    return RAW_TAG[8*(RAW_TAG_LEN-1-i) +: 8];
  endfunction

  function automatic logic [7:0] frame_at(input int unsigned i);
    if (i > FRAME_LAST) return CH_NUL;
    return BLOB_FRAME[8*(FRAME_LAST-i) +: 8];
  endfunction

  // Advance the predicted parser by one byte; return 1 when it decides.
  function automatic bit classify_byte(input in_item_t it, output out_item_t res);
    logic [7:0]  b;
    logic [1:0]  f;
    logic [1:0]  st;
    logic [31:0] pos, off, plen, tot;
    logic [63:0] acc;
    logic [32:0] idx;
    bit          hit;
    b    = it.data_byte;
    res  = '0;
    hit  = 1'b0;
    st   = ST_BAD;
    off  = '0;
    plen = '0;
    tot  = '0;
    if (it.first_of_buffer) begin
      avail_q  = it.bytes_available;
      pos_q    = '0;
      length_q = '0;
      cand_q   = 2'b11;
      digit_q  = 1'b0;
      phase_q  = IN_TAG;
      if (avail_q == 0) hit = 1'b1;
    end else if (phase_q == WAIT_FIRST) begin
      return 1'b0;
    end
    if (!hit) begin
      pos = pos_q;
      case (phase_q)
        IN_TAG: begin
          f = cand_q;
          if (pos >= RAW_TAG_LEN || b != raw_at(pos)) f[0] = 1'b0;
          if (pos > BLOB_TAG_END || b != frame_at(pos)) f[1] = 1'b0;
          cand_q = f;
          if (f[0] && pos == RAW_TAG_LEN - 1) phase_q = IN_RAW_TEXT;
          else if (f[1] && pos == BLOB_TAG_END) phase_q = IN_FRAME;
          else if (f == 2'b00) begin
            hit = 1'b1;
            st  = ST_OTHER;
          end
        end
        IN_RAW_TEXT: begin
          if (b == CH_NUL) begin
            hit  = 1'b1;
            st   = ST_RAW;
            off  = RAW_TAG_LEN;
            plen = pos - (RAW_TAG_LEN - 1);
            tot  = pos + 1;
          end
        end
        IN_FRAME: begin
          if (pos > FRAME_LAST || (pos != SKIP_POS && b != frame_at(pos))) hit = 1'b1;
          else if (pos == FRAME_LAST) begin
            phase_q  = IN_DIGITS;
            length_q = '0;
            digit_q  = 1'b0;
          end
        end
        IN_DIGITS: begin
          if (b >= CH_ZERO && b <= CH_NINE) begin
            acc      = length_q * 64'd10 + b - CH_ZERO;
            length_q = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
            digit_q  = 1'b1;
          end else if (b == CH_COLON && digit_q) begin
            phase_q = AT_TERM;
          end else begin
            hit = 1'b1;
          end
        end
        AT_TERM: begin
          idx = {1'b0, pos} + 33'd1;
          hit = 1'b1;
          if (b == CH_NUL && idx <= {1'b0, avail_q} &&
              {1'b0, length_q} <= {1'b0, avail_q} - idx) begin
            st   = ST_BLOB;
            off  = idx[31:0];
            plen = length_q;
            tot  = idx[31:0] + length_q;
          end
        end
        default: return 1'b0;
      endcase
      if (!hit) begin
        // out of bytes: not ours while still in the tag or raw text
        if ({1'b0, pos} + 33'd1 >= {1'b0, avail_q}) begin
          hit = 1'b1;
          st  = (phase_q == IN_TAG || phase_q == IN_RAW_TEXT) ? ST_OTHER : ST_BAD;
        end else begin
          pos_q = pos + 1;
        end
      end
    end
    if (hit) begin
      phase_q = WAIT_FIRST;
      res     = '{st, off, plen, tot};
    end
    return hit;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic first, input logic [31:0] avail);
    in_item_t    it;
    out_item_t   res;
    int unsigned gap;
    it.data_byte       = b;
    it.first_of_buffer = first;
    it.bytes_available = avail;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    live_count++;
    if (classify_byte(it, res)) verdict_q.push_back(res);
  endtask

  task automatic send_stream(input logic [31:0] avail);
    int unsigned i;
    for (i = 0; i < stream_q.size(); i++)
      send_byte(stream_q[i], i == 0, (i == 0) ? avail : $urandom());
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) stream_q.push_back(s[i]);
  endtask

  task automatic corrupt_header();
    stream_q[$urandom_range(0, stream_q.size() - 1)] = 8'($urandom_range(0, 255));
  endtask

  function automatic logic [31:0] pick_avail(input logic [63:0] need);
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0:       v = need;
      1:       v = need - 1;
      2:       v = need + $urandom_range(1, 8);
      3:       v = 64'hFFFF_FFFF;
      4:       v = 64'($urandom_range(0, 40));
      default: v = {32'd0, $urandom()};
    endcase
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  task automatic build_raw(output logic [63:0] need);
    stream_q.delete();
    push_text("raw:");
    repeat ($urandom_range(0, 12)) stream_q.push_back(8'($urandom_range(1, 255)));
    stream_q.push_back(CH_NUL);
    need = 64'(stream_q.size());
    if ($urandom_range(0, 6) == 0) corrupt_header();
    repeat ($urandom_range(0, 2)) stream_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic build_blob(output logic [63:0] need);
    int unsigned i;
    logic [31:0] val;
    string       digits;
    stream_q.delete();
    for (i = 0; i <= FRAME_LAST; i++)
      stream_q.push_back((i == SKIP_POS) ? 8'($urandom_range(0, 255)) : frame_at(i));
    case ($urandom_range(0, 9))
      6: begin
        val    = $urandom_range(0, 99);
        digits = $sformatf("%0d", val);
        repeat ($urandom_range(1, 3)) digits = {"0", digits};
      end
      7: begin
        // saturating lengths, around and above the 32-bit limit
        val = 32'hFFFF_FFFF;
        case ($urandom_range(0, 2))
          0:       digits = "4294967295";
          1:       digits = "4294967296";
          default: begin
            digits = "";
            repeat ($urandom_range(11, 12))
              digits = {digits, $sformatf("%0d", $urandom_range(1, 9))};
          end
        endcase
      end
      8: begin
        val    = $urandom();
        digits = $sformatf("%0d", val);
      end
      9: begin
        // missing digits, leading space or sign
        val = '0;
        case ($urandom_range(0, 3))
          0:       digits = "";
          1:       digits = " 5";
          2:       digits = "+7";
          default: digits = "-1";
        endcase
      end
      default: begin
        val    = $urandom_range(0, 8);
        digits = $sformatf("%0d", val);
      end
    endcase
    push_text(digits);
    stream_q.push_back(CH_COLON);
    stream_q.push_back(CH_NUL);
    need = 64'(stream_q.size()) + 64'(val);
    if ($urandom_range(0, 6) == 0) corrupt_header();
    repeat ((val < 3) ? val : 3) stream_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic test_ignored_bytes();
    send_byte(8'hFF, 1'b0, 32'hFFFF_FFFF);
    send_byte(CH_NUL, 1'b0, 32'h0);
  endtask

  task automatic test_zero_available();
    stream_q.delete();
    stream_q.push_back(8'hFF);
    stream_q.push_back("r");
    send_stream(32'd0);
  endtask

  task automatic test_tag_runout();
    stream_q.delete();
    push_text("ra");
    send_stream(32'd2);
    stream_q.delete();
    push_text("raw:");
    send_stream(RAW_TAG_LEN);
    stream_q.delete();
    push_text("q");
    send_stream(32'hFFFF_FFFF);
  endtask

  task automatic test_raw_headers();
    stream_q.delete();
    push_text("raw:");
    stream_q.push_back(CH_NUL);
    send_stream(32'd5);
    stream_q.delete();
    push_text("raw:a");
    stream_q.push_back(CH_NUL);
    stream_q.push_back(8'hFF);
    send_stream(32'hFFFF_FFFF);
  endtask

  task automatic test_buffer_restart();
    stream_q.delete();
    push_text("blo");
    send_stream(32'd100);
    stream_q.delete();
    push_text("raw:");
    stream_q.push_back(CH_NUL);
    send_stream(32'd5);
  endtask

  task automatic test_random_buffers();
    int unsigned start, kind, keep;
    logic [63:0] need;
    start = live_count;
    while (live_count - start < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) build_blob(need);
      else if (kind < 80) build_raw(need);
      else begin
        stream_q.delete();
        case ($urandom_range(0, 2))
          0:       stream_q.push_back("r");
          1:       stream_q.push_back("b");
          default: stream_q.push_back(8'($urandom_range(0, 255)));
        endcase
        repeat ($urandom_range(0, 5)) stream_q.push_back(8'($urandom_range(0, 255)));
        need = 64'(stream_q.size());
      end
      // drop the tail so the next first byte restarts mid-buffer
      if ($urandom_range(0, 9) == 0 && stream_q.size() > 1) begin
        keep = $urandom_range(1, stream_q.size() - 1);
        while (stream_q.size() > keep) void'(stream_q.pop_back());
      end
      send_stream(pick_avail(need));
    end
  endtask

  // receiver stall pattern: runs of no stall, light, half and heavy stalling
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_run  <= $urandom_range(8, 64);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 1) == 1);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $error("result with nothing expected: status %0d", out_item.status);
        fail_count++;
      end else begin
        want = verdict_q.pop_front();
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          fail_count++;
        end
        if (out_item.payload_offset !== want.payload_offset) begin
          $error("payload_offset: expected %0d, got %0d",
                 want.payload_offset, out_item.payload_offset);
          fail_count++;
        end
        if (out_item.payload_length !== want.payload_length) begin
          $error("payload_length: expected %0d, got %0d",
                 want.payload_length, out_item.payload_length);
          fail_count++;
        end
        if (out_item.consumed_total !== want.consumed_total) begin
          $error("consumed_total: expected %0d, got %0d",
                 want.consumed_total, out_item.consumed_total);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_ignored_bytes();
    test_zero_available();
    test_tag_runout();
    test_raw_headers();
    test_buffer_restart();
    test_random_buffers();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    // let any request still in flight drain out
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
